// ===== src/grid_ray_dda_traversal_defines.svh =====
// ----------------------------------------------------------------------------
// grid_ray_dda_traversal_defines
// Assertion macros shared by the ray walker. Each one expects i_clk and
// i_rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_DDA_TRAVERSAL_DEFINES_SVH
`define GRID_RAY_DDA_TRAVERSAL_DEFINES_SVH

// Same-cycle implication, checked out of reset only.
`define GRDT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset only.
`define GRDT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/grdt_pkg.sv =====
// ----------------------------------------------------------------------------
// grdt_pkg
// Widths, codes and the command/status bundles of the grid ray walker.
// ----------------------------------------------------------------------------
package grdt_pkg;

    // Defaults of the top-level parameters
    localparam int DEF_MAP_SIDE  = 64;
    localparam int DEF_DIST_BITS = 32;

    // Fixed field widths
    localparam int IN_CELL_W = 6;
    localparam int IN_DIST_W = 32;
    localparam int PERP_W    = 32;
    localparam int FACE_W    = 2;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Walk coordinates share the width of the size registers
    localparam int COORD_W = CFG_W;

    // Reset value of both size registers, clipped to MAP_SIDE
    localparam int CFG_RESET = 64;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 1'b1;

    // Opcodes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    // Wall faces
    localparam logic [FACE_W-1:0] FACE_EAST  = 2'd0;
    localparam logic [FACE_W-1:0] FACE_WEST  = 2'd1;
    localparam logic [FACE_W-1:0] FACE_SOUTH = 2'd2;
    localparam logic [FACE_W-1:0] FACE_NORTH = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic clear_en;   // zero one map cell, advance the clear address
        logic cell_wr;    // write one map cell from the input item
        logic load;       // load a cast item
        logic walk;       // walk one step
        logic out_load;   // move the finished result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_last; // clear address is on the last cell
        logic walk_done;  // the walk ends at this edge
    } t_sts;

endpackage

// ===== src/grdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// grdt_ctrl
// Sequencer of the ray walker: clear pass, item intake, walk, result handoff.
// ----------------------------------------------------------------------------
module grdt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_opcode,
    input  logic            i_out_stall,
    input  grdt_pkg::t_sts  i_sts,
    output grdt_pkg::t_cmd  o_cmd,
    output logic            o_in_stall,
    output logic            o_out_valid
);
    import grdt_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_WALK  = 4'b0100,
        S_HOLD  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    t_cmd   cmd;

    assign accept = (r_state == S_IDLE) && i_in_valid;

    always_comb begin
        cmd          = '0;
        cmd.clear_en = (r_state == S_CLEAR);
        cmd.cell_wr  = accept && (i_opcode == OP_WRITE);
        cmd.load     = accept && (i_opcode == OP_CAST);
        cmd.walk     = (r_state == S_WALK);
        cmd.out_load = (r_state == S_HOLD) && (!r_out_valid || !i_out_stall);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (cmd.load) n_state = S_WALK;
            end
            S_WALK: begin
                if (i_sts.walk_done) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (cmd.out_load) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Keep valid while the result waits, refill on handoff
    assign n_out_valid = cmd.out_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/grdt_dp.sv =====
// ----------------------------------------------------------------------------
// grdt_dp
// Datapath of the ray walker: wall map, size registers, DDA step unit and
// the output register.
// ----------------------------------------------------------------------------
module grdt_dp #(
    parameter int MAP_SIDE  = grdt_pkg::DEF_MAP_SIDE,
    parameter int DIST_BITS = grdt_pkg::DEF_DIST_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  grdt_pkg::t_cmd                 i_cmd,
    output grdt_pkg::t_sts                 o_sts,
    input  logic                           i_cfg_we,
    input  logic [grdt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [grdt_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [grdt_pkg::IN_CELL_W-1:0] i_cell_col,
    input  logic [grdt_pkg::IN_CELL_W-1:0] i_cell_row,
    input  logic                           i_wall_bit,
    input  logic [grdt_pkg::IN_DIST_W-1:0] i_side_dist_col,
    input  logic [grdt_pkg::IN_DIST_W-1:0] i_side_dist_row,
    input  logic [grdt_pkg::IN_DIST_W-1:0] i_delta_col,
    input  logic [grdt_pkg::IN_DIST_W-1:0] i_delta_row,
    input  logic                           i_step_col_neg,
    input  logic                           i_step_row_neg,
    output logic [grdt_pkg::IN_CELL_W-1:0] o_hit_col,
    output logic [grdt_pkg::IN_CELL_W-1:0] o_hit_row,
    output logic                           o_side_crossed,
    output logic [grdt_pkg::FACE_W-1:0]    o_wall_face,
    output logic [grdt_pkg::PERP_W-1:0]    o_perp_distance,
    output logic                           o_left_map
);
    import grdt_pkg::*;

    localparam int CELLS = MAP_SIDE * MAP_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int XW0   = (IN_DIST_W > PERP_W) ? IN_DIST_W : PERP_W;
    localparam int XW    = (DIST_BITS > XW0) ? DIST_BITS : XW0;
    localparam logic [DIST_BITS-1:0] DIST_MAX  = '1;
    localparam logic [PERP_W-1:0]    PERP_MAX  = '1;
    localparam logic [COORD_W-1:0]   ACT_RESET = (CFG_RESET > MAP_SIDE) ?
                                                 COORD_W'(MAP_SIDE) : COORD_W'(CFG_RESET);

    function automatic logic [DIST_BITS-1:0] sat_in(input logic [IN_DIST_W-1:0] v);
        logic [XW-1:0] vx;
        vx = XW'(v);
        return (vx > XW'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(v);
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] row,
                                                input logic [COORD_W-1:0] col);
        return AW'(row) * AW'(MAP_SIDE) + AW'(col);
    endfunction

    function automatic logic [COORD_W-1:0] act_size(input logic [CFG_W-1:0] v);
        return (int'(v) > MAP_SIDE) ? COORD_W'(MAP_SIDE) : COORD_W'(v);
    endfunction

    // Active map size
    logic [COORD_W-1:0] r_act_w;
    logic [COORD_W-1:0] r_act_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_w <= ACT_RESET;
            r_act_h <= ACT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAP_WIDTH:  r_act_w <= act_size(i_cfg_data);
                REG_MAP_HEIGHT: r_act_h <= act_size(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Walk state
    logic [COORD_W-1:0]   r_col;
    logic [COORD_W-1:0]   r_row;
    logic [DIST_BITS-1:0] r_sd_c;
    logic [DIST_BITS-1:0] r_sd_r;
    logic [DIST_BITS-1:0] r_dl_c;
    logic [DIST_BITS-1:0] r_dl_r;
    logic                 r_neg_c;
    logic                 r_neg_r;
    logic                 r_side;
    logic [FACE_W-1:0]    r_face;
    logic [DIST_BITS-1:0] r_perp;
    logic                 r_left;
    logic                 r_outside;
    logic                 r_chk;
    logic                 r_rd_data;
    logic [AW-1:0]        r_clr_cnt;

    // Step unit
    logic                 col_step;
    logic [COORD_W:0]     col_inc;
    logic [COORD_W:0]     row_inc;
    logic                 exit_c;
    logic                 exit_r;
    logic                 step_exit;
    logic                 wall;
    logic [DIST_BITS:0]   sum_c;
    logic [DIST_BITS:0]   sum_r;
    logic [DIST_BITS-1:0] sat_c;
    logic [DIST_BITS-1:0] sat_r;
    logic [COORD_W-1:0]   n_col;
    logic [COORD_W-1:0]   n_row;
    logic [AW-1:0]        rd_addr;

    assign col_step  = (r_sd_c < r_sd_r);
    assign col_inc   = {1'b0, r_col} + {{COORD_W{1'b0}}, 1'b1};
    assign row_inc   = {1'b0, r_row} + {{COORD_W{1'b0}}, 1'b1};
    assign exit_c    = r_neg_c ? (r_col == '0) : (col_inc >= {1'b0, r_act_w});
    assign exit_r    = r_neg_r ? (r_row == '0) : (row_inc >= {1'b0, r_act_h});
    assign step_exit = col_step ? exit_c : exit_r;
    assign wall      = r_chk && r_rd_data;

    assign sum_c = {1'b0, r_sd_c} + {1'b0, r_dl_c};
    assign sum_r = {1'b0, r_sd_r} + {1'b0, r_dl_r};
    assign sat_c = sum_c[DIST_BITS] ? DIST_MAX : sum_c[DIST_BITS-1:0];
    assign sat_r = sum_r[DIST_BITS] ? DIST_MAX : sum_r[DIST_BITS-1:0];

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_step && !exit_c) begin
            n_col = r_neg_c ? (r_col - COORD_W'(1)) : col_inc[COORD_W-1:0];
        end
        if (!col_step && !exit_r) begin
            n_row = r_neg_r ? (r_row - COORD_W'(1)) : row_inc[COORD_W-1:0];
        end
    end

    assign rd_addr = cell_addr(n_row, n_col);

    assign o_sts.walk_done  = r_outside || wall || step_exit;
    assign o_sts.clear_last = (r_clr_cnt == AW'(CELLS - 1));

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk     <= 1'b0;
            r_outside <= 1'b0;
            r_clr_cnt <= '0;
        end else begin
            if (i_cmd.clear_en) begin
                r_clr_cnt <= r_clr_cnt + AW'(1);
            end
            if (i_cmd.load) begin
                r_chk     <= 1'b0;
                r_outside <= !((COORD_W'(i_cell_col) < r_act_w) &&
                               (COORD_W'(i_cell_row) < r_act_h));
            end else if (i_cmd.walk) begin
                r_chk <= !r_outside && !wall && !step_exit;
            end
        end
    end

    // Walk payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_col   <= COORD_W'(i_cell_col);
            r_row   <= COORD_W'(i_cell_row);
            r_sd_c  <= sat_in(i_side_dist_col);
            r_sd_r  <= sat_in(i_side_dist_row);
            r_dl_c  <= sat_in(i_delta_col);
            r_dl_r  <= sat_in(i_delta_row);
            r_neg_c <= i_step_col_neg;
            r_neg_r <= i_step_row_neg;
            r_side  <= 1'b0;
            r_face  <= FACE_EAST;
            r_perp  <= '0;
            r_left  <= 1'b1;
        end else if (i_cmd.walk && !r_outside) begin
            if (wall) begin
                r_left <= 1'b0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
                if (col_step) begin
                    r_side <= 1'b0;
                    r_face <= r_neg_c ? FACE_WEST : FACE_EAST;
                    r_perp <= r_sd_c;
                    r_sd_c <= sat_c;
                end else begin
                    r_side <= 1'b1;
                    r_face <= r_neg_r ? FACE_NORTH : FACE_SOUTH;
                    r_perp <= r_sd_r;
                    r_sd_r <= sat_r;
                end
            end
        end
    end

    // Wall map: one write port, one registered read port
    logic          r_wall_map [CELLS];
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;
    logic          wr_in_range;

    assign wr_in_range = (int'(i_cell_col) < MAP_SIDE) && (int'(i_cell_row) < MAP_SIDE);
    assign wr_en       = i_cmd.clear_en || (i_cmd.cell_wr && wr_in_range);
    assign wr_addr     = i_cmd.clear_en ? r_clr_cnt :
                         cell_addr(COORD_W'(i_cell_row), COORD_W'(i_cell_col));
    assign wr_data     = i_cmd.clear_en ? 1'b0 : i_wall_bit;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wall_map[wr_addr] <= wr_data;
        end
        r_rd_data <= r_wall_map[rd_addr];
    end

    // Output register
    logic [XW-1:0] perp_x;

    assign perp_x = XW'(r_perp);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_hit_col       <= r_col[IN_CELL_W-1:0];
            o_hit_row       <= r_row[IN_CELL_W-1:0];
            o_side_crossed  <= r_side;
            o_wall_face     <= r_face;
            o_perp_distance <= (perp_x > XW'(PERP_MAX)) ? PERP_MAX : PERP_W'(r_perp);
            o_left_map      <= r_left;
        end
    end

endmodule

// ===== src/grid_ray_dda_traversal.sv =====
// ----------------------------------------------------------------------------
// grid_ray_dda_traversal
// Two-dimensional DDA ray walker over a bit map of wall cells.
//
//   channel  direction  handshake                 moves
//   -------  ---------  ------------------------  ----------------------------
//   in       sink       i_in_valid / o_in_stall   write item or cast item
//   out      source     o_out_valid / i_out_stall result item, one per cast
//   cfg      sink       i_cfg_we                  map_width, map_height
//
// A write item is written to the map as it is taken. A cast item is loaded,
// then walked one cell stepped per cycle, a wall cell being seen from the
// registered map read after the step into it, and then waits until the
// output register is free to hand its result over. One map read per step
// sets that pace. After reset the map is cleared one cell a cycle over
// MAP_SIDE * MAP_SIDE cells (4096 at the default), with the input stalled;
// size writes are taken. A waiting result does not block the next item;
// only a finished cast waits for the output register to free.
// ----------------------------------------------------------------------------
`include "grid_ray_dda_traversal_defines.svh"

module grid_ray_dda_traversal #(
    parameter int MAP_SIDE  = grdt_pkg::DEF_MAP_SIDE,
    parameter int DIST_BITS = grdt_pkg::DEF_DIST_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration
    input  logic                           i_cfg_we,
    input  logic [grdt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [grdt_pkg::CFG_W-1:0]     i_cfg_data,
    // Input items
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_opcode,
    input  logic [grdt_pkg::IN_CELL_W-1:0] i_cell_col,
    input  logic [grdt_pkg::IN_CELL_W-1:0] i_cell_row,
    input  logic                           i_wall_bit,
    input  logic [grdt_pkg::IN_DIST_W-1:0] i_side_dist_col,
    input  logic [grdt_pkg::IN_DIST_W-1:0] i_side_dist_row,
    input  logic [grdt_pkg::IN_DIST_W-1:0] i_delta_col,
    input  logic [grdt_pkg::IN_DIST_W-1:0] i_delta_row,
    input  logic                           i_step_col_neg,
    input  logic                           i_step_row_neg,
    // Result items
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [grdt_pkg::IN_CELL_W-1:0] o_hit_col,
    output logic [grdt_pkg::IN_CELL_W-1:0] o_hit_row,
    output logic                           o_side_crossed,
    output logic [grdt_pkg::FACE_W-1:0]    o_wall_face,
    output logic [grdt_pkg::PERP_W-1:0]    o_perp_distance,
    output logic                           o_left_map
);
    import grdt_pkg::*;

    t_cmd s_cmd;
    t_sts s_sts;

    // Sequencer: clear pass, intake, walk, handoff
    grdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_out_stall (i_out_stall),
        .i_sts       (s_sts),
        .o_cmd       (s_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // Map, step unit and output register
    grdt_dp #(
        .MAP_SIDE  (MAP_SIDE),
        .DIST_BITS (DIST_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (s_cmd),
        .o_sts           (s_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cell_col      (i_cell_col),
        .i_cell_row      (i_cell_row),
        .i_wall_bit      (i_wall_bit),
        .i_side_dist_col (i_side_dist_col),
        .i_side_dist_row (i_side_dist_row),
        .i_delta_col     (i_delta_col),
        .i_delta_row     (i_delta_row),
        .i_step_col_neg  (i_step_col_neg),
        .i_step_row_neg  (i_step_row_neg),
        .o_hit_col       (o_hit_col),
        .o_hit_row       (o_hit_row),
        .o_side_crossed  (o_side_crossed),
        .o_wall_face     (o_wall_face),
        .o_perp_distance (o_perp_distance),
        .o_left_map      (o_left_map)
    );

    // Never overwrite a result that is still waiting
    `GRDT_ASSERT_SAME(a_out_load_free, s_cmd.out_load, !o_out_valid || !i_out_stall, "result overwritten")

    // A finished walk stops and does not start a new cast
    `GRDT_ASSERT_NEXT(a_walk_ends, s_cmd.walk && s_sts.walk_done, !s_cmd.walk && !s_cmd.load, "walk did not stop")

    // Face and crossed side always agree on the axis
    `GRDT_ASSERT_SAME(a_face_side, o_out_valid, o_wall_face[1] == o_side_crossed, "face and side disagree")

endmodule
